### rtl/core/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off while in reset.
`define CNS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("stencil check failed");

// Next-cycle implication, sampled on i_clk, off while in reset.
`define CNS_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("stencil check failed");

`endif

### rtl/core/cns_pkg.sv
// Shared constants and types of the five-point stencil sum block.
package cns_pkg;

    localparam int DEF_MAX_ROWS    = 1024;
    localparam int DEF_MAX_COLS    = 1024;
    localparam int DEF_SAMPLE_BITS = 16;

    localparam int CFG_DATA_W  = 11;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [CFG_DATA_W-1:0] RST_COLS = 11'd4;
    localparam logic [CFG_DATA_W-1:0] RST_ROWS = 11'd3;

    typedef enum logic [0:0] {
        CFG_COLS = 1'b0,
        CFG_ROWS = 1'b1
    } t_cfg_idx;

    // Which of the three possible results one word produces.
    typedef struct packed {
        logic up_cell;     // cell one row above the incoming sample
        logic left_cell;   // last row, cell one column to the left
        logic final_cell;  // last cell of the frame
    } t_emit;

endpackage

### rtl/core/cross_neighbour_sum_stencil.sv
// Five-point stencil sum over a raster-order matrix stream: top level.
// Samples enter in raster order at up to one word per clock. Each accepted
// sample gives zero to three result words: the cell one row above it, and on
// the last row also the cell to its left, and at the final cell that cell
// itself, flagged by frame_end; run_last marks the last word a sample caused.
// The front end reads each line store one column ahead, so a sample is taken
// every cycle unless the queue is full or a config write is made; a 4-entry
// queue sends results at one word per clock while i_ready is high, so on rows
// that give one result per sample the rate is one sample per cycle; on the
// last row, with up to three words per sample, it drops once the queue fills.
// A config write restarts the frame at row 0, column 0; a dimension of 0 acts
// as 1 and one above the maximum as the maximum. Line stores start unwritten;
// their content only reaches a result once the frame has filled it.
module cross_neighbour_sum_stencil import cns_pkg::*; #(
    parameter int MAX_ROWS    = DEF_MAX_ROWS,
    parameter int MAX_COLS    = DEF_MAX_COLS,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
    localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
    localparam int COL_W = $clog2(MAX_COLS),
    localparam int SUM_W = SAMPLE_BITS + 3
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  t_cfg_idx                      i_cfg_index,
    input  logic [CFG_DATA_W-1:0]         i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [SUM_W-1:0]       o_neighbour_sum,
    output logic [ROW_W-1:0]              o_out_row,
    output logic [COL_W-1:0]              o_out_col,
    output logic                          o_run_last,
    output logic                          o_frame_end
);

    localparam int ENTRY_W = $bits(t_emit) + 3 * SUM_W + ROW_W + COL_W;

    t_emit                   f_emit, b_emit;
    logic signed [SUM_W-1:0] f_sum_up, f_sum_left, f_sum_final;
    logic signed [SUM_W-1:0] b_sum_up, b_sum_left, b_sum_final;
    logic [ROW_W-1:0]        f_row, b_row;
    logic [COL_W-1:0]        f_col, b_col;
    logic                    f_valid, f_ready, b_valid, b_ready;
    logic [ENTRY_W-1:0]      q_in, q_out;

    assign o_cfg_ready = 1'b1;

    cns_front #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLS    (MAX_COLS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .ROW_W       (ROW_W),
        .COL_W       (COL_W),
        .SUM_W       (SUM_W)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_sample    (i_sample),
        .o_q_valid   (f_valid),
        .i_q_ready   (f_ready),
        .o_emit      (f_emit),
        .o_sum_up    (f_sum_up),
        .o_sum_left  (f_sum_left),
        .o_sum_final (f_sum_final),
        .o_row       (f_row),
        .o_col       (f_col)
    );

    assign q_in = {f_emit, f_sum_up, f_sum_left, f_sum_final, f_row, f_col};

    cns_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (f_valid),
        .o_push_ready (f_ready),
        .i_data       (q_in),
        .o_pop_valid  (b_valid),
        .i_pop_ready  (b_ready),
        .o_data       (q_out)
    );

    assign {b_emit, b_sum_up, b_sum_left, b_sum_final, b_row, b_col} = q_out;

    cns_back #(
        .ROW_W (ROW_W),
        .COL_W (COL_W),
        .SUM_W (SUM_W)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (b_valid),
        .o_q_ready       (b_ready),
        .i_emit          (b_emit),
        .i_sum_up        (b_sum_up),
        .i_sum_left      (b_sum_left),
        .i_sum_final     (b_sum_final),
        .i_row           (b_row),
        .i_col           (b_col),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_neighbour_sum (o_neighbour_sum),
        .o_out_row       (o_out_row),
        .o_out_col       (o_out_col),
        .o_run_last      (o_run_last),
        .o_frame_end     (o_frame_end)
    );

endmodule

### rtl/core/cns_queue.sv
// Small FIFO between the front end and the result sequencer.
module cns_queue import cns_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_valid,
    output logic             o_push_ready,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_pop_valid,
    input  logic             i_pop_ready,
    output logic [WIDTH-1:0] o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             push, pop;

    assign o_push_ready = (r_count != CNT_W'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_data       = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

### rtl/core/cns_front.sv
// Front end: config registers, position counters, line stores and stencil adders.
module cns_front import cns_pkg::*; #(
    parameter int MAX_ROWS    = DEF_MAX_ROWS,
    parameter int MAX_COLS    = DEF_MAX_COLS,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
    parameter int ROW_W       = 10,
    parameter int COL_W       = 10,
    parameter int SUM_W       = 19
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    input  t_cfg_idx                      i_cfg_index,
    input  logic [CFG_DATA_W-1:0]         i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    output logic                          o_q_valid,
    input  logic                          i_q_ready,
    output t_emit                         o_emit,
    output logic signed [SUM_W-1:0]       o_sum_up,
    output logic signed [SUM_W-1:0]       o_sum_left,
    output logic signed [SUM_W-1:0]       o_sum_final,
    output logic [ROW_W-1:0]              o_row,
    output logic [COL_W-1:0]              o_col
);

    // Clamp a dimension to 1..bound and return it minus one.
    function automatic logic [31:0] clamp_last(input logic [CFG_DATA_W-1:0] v,
                                               input logic [31:0] bound);
        logic [31:0] wide;
        wide = 32'(v);
        if (wide == 32'd0) begin
            return 32'd0;
        end
        if (wide > bound) begin
            return bound - 32'd1;
        end
        return wide - 32'd1;
    endfunction

    function automatic logic signed [SUM_W-1:0] ext(input logic signed [SAMPLE_BITS-1:0] v);
        return {{(SUM_W - SAMPLE_BITS){v[SAMPLE_BITS-1]}}, v};
    endfunction

    logic [COL_W-1:0] r_last_col, r_col;
    logic [ROW_W-1:0] r_last_row, r_row;

    logic signed [SAMPLE_BITS-1:0] r_prev_line  [MAX_COLS];
    logic signed [SAMPLE_BITS-1:0] r_older_line [MAX_COLS];
    logic signed [SAMPLE_BITS-1:0] r_prev_rd, r_old_rd;
    logic                          r_byp_prev, r_byp_old;
    // r_a0: row above at this column; r_l0/r_l1/r_l2: row above at c-1, this row at c-1, c-2
    logic signed [SAMPLE_BITS-1:0] r_a0, r_l0, r_l1, r_l2;

    logic signed [SAMPLE_BITS-1:0] a1, o_val;
    logic [COL_W-1:0]              col_n1, col_n2;
    logic [ROW_W-1:0]              row_n;
    logic                          accept, cfg_we;
    logic                          is_last_row, col_last;
    logic                          row_gt0, row_gt1, col_gt0, col_gt1;

    // a config write takes the cycle; no sample is taken beside it
    assign cfg_we  = i_cfg_valid;
    assign o_ready = i_q_ready && !i_cfg_valid;
    assign accept  = i_valid && o_ready;

    // Bypass values: a read that hit the column being written returns the word just written.
    assign a1    = r_byp_prev ? r_l1 : r_prev_rd;
    assign o_val = r_byp_old  ? r_l0 : r_old_rd;

    assign col_last    = (r_col == r_last_col);
    assign col_n1      = col_last ? '0 : r_col + 1'b1;
    assign col_n2      = (col_n1 == r_last_col) ? '0 : col_n1 + 1'b1;
    assign is_last_row = (r_row == r_last_row);
    assign row_n       = is_last_row ? '0 : r_row + 1'b1;
    assign row_gt0     = (r_row != '0);
    assign row_gt1     = row_gt0 && (r_row != ROW_W'(1));
    assign col_gt0     = (r_col != '0);
    assign col_gt1     = col_gt0 && (r_col != COL_W'(1));

    always_comb begin
        o_emit.up_cell    = row_gt0;
        o_emit.left_cell  = is_last_row && col_gt0;
        o_emit.final_cell = is_last_row && col_last;
        o_q_valid         = i_valid && !i_cfg_valid && (o_emit != '0);

        o_sum_up = ext(r_a0) + ext(i_sample)
                 + (row_gt1   ? ext(o_val) : '0)
                 + (col_gt0   ? ext(r_l0)  : '0)
                 + (!col_last ? ext(a1)    : '0);
        o_sum_left = ext(r_l1) + ext(i_sample)
                   + (row_gt0 ? ext(r_l0) : '0)
                   + (col_gt1 ? ext(r_l2) : '0);
        o_sum_final = ext(i_sample)
                    + (row_gt0 ? ext(r_a0) : '0)
                    + (col_gt0 ? ext(r_l1) : '0);
        o_row = r_row;
        o_col = r_col;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_last_col <= COL_W'(clamp_last(RST_COLS, 32'(MAX_COLS)));
            r_last_row <= ROW_W'(clamp_last(RST_ROWS, 32'(MAX_ROWS)));
        end else if (cfg_we) begin
            case (i_cfg_index)
                CFG_COLS: r_last_col <= COL_W'(clamp_last(i_cfg_data, 32'(MAX_COLS)));
                CFG_ROWS: r_last_row <= ROW_W'(clamp_last(i_cfg_data, 32'(MAX_ROWS)));
                default: ;
            endcase
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            r_col <= col_n1;
            if (col_last) begin
                r_row <= row_n;
            end
        end
    end

    // Line stores: one write at this column, one read ahead per store.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_prev_line[r_col]  <= i_sample;
            r_older_line[r_col] <= r_a0;
            r_prev_rd           <= r_prev_line[col_n2];
            r_old_rd            <= r_older_line[col_n1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_byp_prev <= (col_n2 == r_col);
            r_byp_old  <= (col_n1 == r_col);
            r_a0       <= (col_n1 == r_col) ? i_sample : a1;
            r_l0       <= r_a0;
            r_l1       <= i_sample;
            r_l2       <= r_l1;
        end
    end

endmodule

### rtl/core/cns_back.sv
// Back end: walks the results of one queued word and holds the output register.
module cns_back import cns_pkg::*; #(
    parameter int ROW_W = 10,
    parameter int COL_W = 10,
    parameter int SUM_W = 19
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_q_valid,
    output logic                    o_q_ready,
    input  t_emit                   i_emit,
    input  logic signed [SUM_W-1:0] i_sum_up,
    input  logic signed [SUM_W-1:0] i_sum_left,
    input  logic signed [SUM_W-1:0] i_sum_final,
    input  logic [ROW_W-1:0]        i_row,
    input  logic [COL_W-1:0]        i_col,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic signed [SUM_W-1:0] o_neighbour_sum,
    output logic [ROW_W-1:0]        o_out_row,
    output logic [COL_W-1:0]        o_out_col,
    output logic                    o_run_last,
    output logic                    o_frame_end
);

    t_emit r_done, pend, pick;
    logic  r_valid, load, is_last;
    logic signed [SUM_W-1:0] sel_sum;
    logic [ROW_W-1:0]        sel_row;
    logic [COL_W-1:0]        sel_col;

    always_comb begin
        pend            = t_emit'(i_emit & ~r_done);
        pick.up_cell    = pend.up_cell;
        pick.left_cell  = !pend.up_cell && pend.left_cell;
        pick.final_cell = !pend.up_cell && !pend.left_cell && pend.final_cell;
        is_last         = (t_emit'(pend & ~pick) == '0);

        sel_sum = i_sum_final;
        sel_row = i_row;
        sel_col = i_col;
        if (pick.up_cell) begin
            sel_sum = i_sum_up;
            sel_row = i_row - ROW_W'(1);
        end else if (pick.left_cell) begin
            sel_sum = i_sum_left;
            sel_col = i_col - COL_W'(1);
        end
    end

    assign load      = i_q_valid && (!r_valid || i_ready);
    assign o_q_ready = load && is_last;
    assign o_valid   = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_done  <= '0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_done  <= is_last ? t_emit'('0) : t_emit'(r_done | pick);
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            o_neighbour_sum <= sel_sum;
            o_out_row       <= sel_row;
            o_out_col       <= sel_col;
            o_run_last      <= is_last;
            o_frame_end     <= pick.final_cell;
        end
    end

endmodule

### rtl/core/cns_checker.sv
// Port-level checks on the stencil block's result channel, bound to the top level.
`include "assert_macros.svh"

module cns_checker #(
    parameter int ROW_W = 10,
    parameter int COL_W = 10,
    parameter int SUM_W = 19
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_valid,
    input logic             i_ready,
    input logic [SUM_W-1:0] o_neighbour_sum,
    input logic [ROW_W-1:0] o_out_row,
    input logic [COL_W-1:0] o_out_col,
    input logic             o_run_last,
    input logic             o_frame_end
);

    logic [SUM_W+ROW_W+COL_W+1:0] out_word;

    assign out_word = {o_neighbour_sum, o_out_row, o_out_col, o_run_last, o_frame_end};

    // a stalled result word keeps its contents
    `CNS_ASSERT_NXT(a_out_hold, o_valid && !i_ready, o_valid && $stable(out_word))

    // the final cell is always the last word of its run
    `CNS_ASSERT_IMP(a_end_is_last, o_valid && o_frame_end, o_run_last)

    // nothing is shown straight out of reset
    `CNS_ASSERT_IMP(a_rst_empty, $past(!i_rst_n), !o_valid)

endmodule

bind cross_neighbour_sum_stencil cns_checker #(
    .ROW_W (ROW_W),
    .COL_W (COL_W),
    .SUM_W (SUM_W)
) u_cns_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_valid         (o_valid),
    .i_ready         (i_ready),
    .o_neighbour_sum (o_neighbour_sum),
    .o_out_row       (o_out_row),
    .o_out_col       (o_out_col),
    .o_run_last      (o_run_last),
    .o_frame_end     (o_frame_end)
);

### tb/sv/tb_top.sv
// Self-checking testbench for the five-point stencil sum block.
module tb_top import cns_pkg::*;;

    typedef struct {
        logic signed [18:0] sum;
        logic [9:0]         row;
        logic [9:0]         col;
        logic               run_last;
        logic               frame_end;
    } t_stencil_word;

    // Tracks frame position and line history; queues the cells each sample completes.
    class t_stencil_scoreboard;
        logic [CFG_DATA_W-1:0] cols_reg;
        logic [CFG_DATA_W-1:0] rows_reg;
        int                    line_above[DEF_MAX_COLS];
        int                    line_two_up[DEF_MAX_COLS];
        int                    cur_row;
        int                    cur_col;
        int                    left_prev_row;
        int                    left_this_row;
        t_stencil_word         pending_cells[$];
        int unsigned           errors;

        function new();
            cols_reg = RST_COLS;
            rows_reg = RST_ROWS;
            foreach (line_above[k]) begin
                line_above[k]  = 0;
                line_two_up[k] = 0;
            end
            cur_row       = 0;
            cur_col       = 0;
            left_prev_row = 0;
            left_this_row = 0;
            errors        = 0;
        endfunction

        // 0 acts as 1, anything past the maximum saturates
        function int eff(logic [CFG_DATA_W-1:0] v);
            if (v < 1) return 1;
            if (v > DEF_MAX_COLS) return DEF_MAX_COLS;
            return int'(v);
        endfunction

        function void write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] v);
            if (idx == CFG_COLS) cols_reg = v;
            else rows_reg = v;
            cur_row = 0;
            cur_col = 0;
        endfunction

        function t_stencil_word make_cell(int acc, int r, int c, logic fend);
            t_stencil_word item;
            item.sum       = 19'(acc);
            item.row       = 10'(r);
            item.col       = 10'(c);
            item.run_last  = 1'b0;
            item.frame_end = fend;
            return item;
        endfunction

        function void note_sample(logic signed [15:0] smp);
            int            nc;
            int            nr;
            int            r;
            int            c;
            int            s;
            int            above;
            int            acc;
            bit            bottom;
            t_stencil_word cells[$];
            nc = eff(cols_reg);
            nr = eff(rows_reg);
            r  = cur_row;
            c  = cur_col;
            s  = smp;
            if (c >= nc) c = nc - 1;
            if (r >= nr) r = nr - 1;
            bottom = (r == nr - 1);
            above  = line_above[c];

            // cell one row up is now complete
            if (r >= 1) begin
                acc = above + s;
                if (r > 1) acc += line_two_up[c];
                if (c > 0) acc += left_prev_row;
                if (c + 1 < nc) acc += line_above[c + 1];
                cells.push_back(make_cell(acc, r - 1, c, 1'b0));
            end
            // on the last row the left cell has no row below
            if (bottom && c >= 1) begin
                acc = left_this_row + s;
                if (r > 0) acc += left_prev_row;
                if (c >= 2) acc += line_above[c - 2];
                cells.push_back(make_cell(acc, r, c - 1, 1'b0));
            end
            if (bottom && c == nc - 1) begin
                acc = s;
                if (r > 0) acc += above;
                if (c > 0) acc += left_this_row;
                cells.push_back(make_cell(acc, r, c, 1'b1));
            end
            if (cells.size() > 0) cells[cells.size() - 1].run_last = 1'b1;
            foreach (cells[k]) pending_cells.push_back(cells[k]);

            left_prev_row  = above;
            left_this_row  = s;
            line_two_up[c] = above;
            line_above[c]  = s;
            c++;
            if (c >= nc) begin
                c = 0;
                r++;
                if (r >= nr) r = 0;
            end
            cur_col = c;
            cur_row = r;
        endfunction

        function void check_result(logic signed [18:0] sum, logic [9:0] row, logic [9:0] col,
                                   logic run_last, logic frame_end);
            t_stencil_word want;
            if (pending_cells.size() == 0) begin
                errors++;
                $display("%0t: unexpected word: sum %0d row %0d col %0d", $time, sum, row, col);
                return;
            end
            want = pending_cells.pop_front();
            if (sum !== want.sum) begin
                errors++;
                $display("%0t: neighbour_sum expected %0d, got %0d", $time, want.sum, sum);
            end
            if (row !== want.row) begin
                errors++;
                $display("%0t: out_row expected %0d, got %0d", $time, want.row, row);
            end
            if (col !== want.col) begin
                errors++;
                $display("%0t: out_col expected %0d, got %0d", $time, want.col, col);
            end
            if (run_last !== want.run_last) begin
                errors++;
                $display("%0t: run_last expected %0b, got %0b", $time, want.run_last, run_last);
            end
            if (frame_end !== want.frame_end) begin
                errors++;
                $display("%0t: frame_end expected %0b, got %0b", $time, want.frame_end,
                         frame_end);
            end
        endfunction
    endclass

    localparam int WRITE_BOTH = 0;
    localparam int WRITE_COLS = 1;
    localparam int WRITE_ROWS = 2;
    localparam int SETTLE_CYCLES = 16;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    t_cfg_idx              i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_valid;
    logic                  o_ready;
    logic signed [15:0]    i_sample;
    logic                  o_valid;
    logic                  i_ready;
    logic signed [18:0]    o_neighbour_sum;
    logic [9:0]            o_out_row;
    logic [9:0]            o_out_col;
    logic                  o_run_last;
    logic                  o_frame_end;

    int src_idle_pct;
    int sink_stall_pct;

    t_stencil_scoreboard sb = new();

    cross_neighbour_sum_stencil dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_sample        (i_sample),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_neighbour_sum (o_neighbour_sum),
        .o_out_row       (o_out_row),
        .o_out_col       (o_out_col),
        .o_run_last      (o_run_last),
        .o_frame_end     (o_frame_end)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    // Handshakes are sampled at the edge; inputs are noted before outputs are checked.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) sb.write_reg(i_cfg_index, i_cfg_data);
            if (i_valid && o_ready) sb.note_sample(i_sample);
            if (o_valid && i_ready)
                sb.check_result(o_neighbour_sum, o_out_row, o_out_col, o_run_last,
                                o_frame_end);
        end
    end

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'hffff;
            3: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic push_sample(logic [15:0] v);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_sample <= v;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic push_random(int count);
        repeat (count) push_sample(pick_sample());
        i_valid <= 1'b0;
    endtask

    // Block must be idle before a register write: all words back, then settle time.
    task automatic drain();
        @(posedge i_clk);
        while (sb.pending_cells.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_dims(int which, logic [CFG_DATA_W-1:0] cols,
                              logic [CFG_DATA_W-1:0] rows);
        drain();
        if (which != WRITE_ROWS) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= CFG_COLS;
            i_cfg_data  <= cols;
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        if (which != WRITE_COLS) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= CFG_ROWS;
            i_cfg_data  <= rows;
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(int quota);
        int                    sent;
        int                    which;
        int                    cells;
        int                    count;
        logic [CFG_DATA_W-1:0] cols;
        logic [CFG_DATA_W-1:0] rows;
        sent = 0;
        cols = sb.cols_reg;
        rows = sb.rows_reg;
        while (sent < quota) begin
            which = $urandom_range(0, 3);
            if (which == 3) which = WRITE_BOTH;
            if (which != WRITE_ROWS)
                cols = ($urandom_range(0, 9) == 0) ? '0 : CFG_DATA_W'($urandom_range(1, 8));
            if (which != WRITE_COLS)
                rows = ($urandom_range(0, 9) == 0) ? '0 : CFG_DATA_W'($urandom_range(1, 6));
            write_dims(which, cols, rows);
            cells = sb.eff(cols) * sb.eff(rows);
            // mostly whole frames; some cut short to exercise the restart
            if ($urandom_range(0, 4) == 0) count = $urandom_range(1, cells);
            else count = cells * $urandom_range(1, 3);
            push_random(count);
            sent += count;
        end
    endtask

    initial begin
        #10_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        i_rst_n     <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_COLS;
        i_cfg_data  <= '0;
        i_valid     <= 1'b0;
        i_sample    <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset dimensions: one frame at the negative extreme, then one at the positive
        repeat (12) push_sample(16'h8000);
        repeat (12) push_sample(16'h7fff);
        i_valid <= 1'b0;

        // zero dimensions act as a single cell
        write_dims(WRITE_BOTH, 11'd0, 11'd0);
        push_sample(16'hffff);
        push_sample(16'h7fff);
        push_sample(16'h8000);
        i_valid <= 1'b0;

        // widest row, tallest column with a saturated row count, a saturated column count, then two columns
        write_dims(WRITE_BOTH, 11'd1024, 11'd1);
        push_random(24);
        write_dims(WRITE_BOTH, 11'd1, 11'd2047);
        push_random(24);
        write_dims(WRITE_BOTH, 11'd2047, 11'd1);
        push_random(10);
        write_dims(WRITE_BOTH, 11'd2, 11'd1024);
        push_random(12);

        random_phase(70);
        src_idle_pct = 53;
        random_phase(70);
        src_idle_pct   = 0;
        sink_stall_pct = 53;
        random_phase(70);
        src_idle_pct   = 10;
        sink_stall_pct = 10;
        random_phase(70);

        drain();
        if (sb.errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
